// File: src/escape_string_unescaper_utf8_defines.svh
// Assertion macros used by the checker file.
`ifndef ESCAPE_STRING_UNESCAPER_UTF8_DEFINES_SVH
`define ESCAPE_STRING_UNESCAPER_UTF8_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ESU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esu check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ESU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esu check failed");

`endif

// File: src/esu_pkg.sv
package esu_pkg;

  typedef enum logic [1:0] {
    PH_TEXT   = 2'd0,
    PH_ESC    = 2'd1,
    PH_DIGITS = 2'd2
  } esu_phase_t;

  typedef struct packed {
    logic        has_a;
    logic [31:0] a_val;
    logic        has_b;
    logic [7:0]  b_val;
    logic        has_c;
  } esu_entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_HT  = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0B;

  localparam logic [3:0] LIM_U     = 4'd4;
  localparam logic [3:0] LIM_BIG_U = 4'd8;
  localparam logic [3:0] LIM_X     = 4'd2;
  localparam logic [3:0] LIM_OCT   = 4'd3;

  localparam logic [31:0] UTF_LIM1 = 32'h0000_0080;
  localparam logic [31:0] UTF_LIM2 = 32'h0000_0800;
  localparam logic [31:0] UTF_LIM3 = 32'h0001_0000;
  localparam logic [31:0] UTF_LIM4 = 32'h0020_0000;
  localparam logic [31:0] UTF_LIM5 = 32'h0400_0000;

  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [7:0] UTF_MASK  = 8'h3F;
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_LEAD5 = 8'hF8;
  localparam logic [7:0] UTF_LEAD6 = 8'hFC;

endpackage

// File: src/esu_queue.sv
module esu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  esu_pkg::esu_entry_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output esu_pkg::esu_entry_t rd_data
);

  esu_pkg::esu_entry_t                   mem [esu_pkg::QUEUE_DEPTH];
  logic [esu_pkg::QUEUE_PTR_W-1:0]       wr_ptr;
  logic [esu_pkg::QUEUE_PTR_W-1:0]       rd_ptr;
  logic [esu_pkg::QUEUE_CNT_W-1:0]       count;
  logic                                  push;
  logic                                  pop;

  localparam logic [esu_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
    esu_pkg::QUEUE_PTR_W'(esu_pkg::QUEUE_DEPTH - 1);
  localparam logic [esu_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
    esu_pkg::QUEUE_CNT_W'(esu_pkg::QUEUE_DEPTH);

  assign wr_ready = count != CNT_FULL;
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/esu_front.sv
module esu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                stream_end,
  output logic                q_valid,
  input  logic                q_ready,
  output esu_pkg::esu_entry_t q_data
);

  esu_pkg::esu_phase_t phase;
  esu_pkg::esu_phase_t phase_mid;
  esu_pkg::esu_phase_t phase_next;
  logic [3:0]          digit_limit;
  logic [3:0]          digit_limit_next;
  logic [3:0]          digits_taken;
  logic [3:0]          digits_taken_next;
  logic                octal_radix;
  logic                octal_radix_next;
  logic [31:0]         code_value;
  logic [31:0]         code_value_next;

  logic                accept;
  logic                is_bslash;
  logic                hex_ok;
  logic [3:0]          hex_digit;
  logic                is_oct;
  logic                digit_ok;
  logic                take;
  logic [3:0]          taken_inc;
  logic                run_full;
  logic [31:0]         shifted;
  logic                simple_hit;
  logic [7:0]          simple_val;
  logic                run_start;
  logic [3:0]          run_lim;
  esu_pkg::esu_entry_t entry;

  assign accept    = in_valid && q_ready;
  assign in_ready  = q_ready;
  assign is_bslash = in_byte == esu_pkg::CH_BSLASH;
  assign is_oct    = (in_byte >= 8'h30) && (in_byte <= 8'h37);
  assign digit_ok  = hex_ok && (!octal_radix || is_oct);
  assign take      = (digits_taken < digit_limit) && digit_ok;
  assign taken_inc = digits_taken + 4'd1;
  assign run_full  = taken_inc >= digit_limit;
  assign shifted   = octal_radix ? {code_value[28:0], hex_digit[2:0]}
                                 : {code_value[27:0], hex_digit};

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    case (in_byte) inside
      [8'h30:8'h39]: hex_digit = 4'(in_byte - 8'h30);
      [8'h61:8'h66]: hex_digit = 4'(in_byte - 8'h57);
      [8'h41:8'h46]: hex_digit = 4'(in_byte - 8'h37);
      default:       hex_ok    = 1'b0;
    endcase
  end

  always_comb begin
    simple_hit = 1'b1;
    simple_val = in_byte;
    run_start  = 1'b0;
    run_lim    = 4'd0;
    unique case (in_byte) inside
      esu_pkg::CH_A:      simple_val = esu_pkg::CTL_BEL;
      esu_pkg::CH_B:      simple_val = esu_pkg::CTL_BS;
      esu_pkg::CH_F:      simple_val = esu_pkg::CTL_FF;
      esu_pkg::CH_N:      simple_val = esu_pkg::CTL_LF;
      esu_pkg::CH_R:      simple_val = esu_pkg::CTL_CR;
      esu_pkg::CH_T:      simple_val = esu_pkg::CTL_HT;
      esu_pkg::CH_V:      simple_val = esu_pkg::CTL_VT;
      esu_pkg::CH_QUOTE,
      esu_pkg::CH_DQUOTE,
      esu_pkg::CH_BSLASH: simple_val = in_byte;
      esu_pkg::CH_LOW_U: begin
        simple_hit = 1'b0;
        run_start  = 1'b1;
        run_lim    = esu_pkg::LIM_U;
      end
      esu_pkg::CH_UP_U: begin
        simple_hit = 1'b0;
        run_start  = 1'b1;
        run_lim    = esu_pkg::LIM_BIG_U;
      end
      esu_pkg::CH_LOW_X: begin
        simple_hit = 1'b0;
        run_start  = 1'b1;
        run_lim    = esu_pkg::LIM_X;
      end
      default:            simple_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (phase)
      esu_pkg::PH_ESC: begin
        phase_mid = (run_start || is_oct) ? esu_pkg::PH_DIGITS : esu_pkg::PH_TEXT;
      end
      esu_pkg::PH_DIGITS: begin
        if (take) begin
          phase_mid = run_full ? esu_pkg::PH_TEXT : esu_pkg::PH_DIGITS;
        end else begin
          phase_mid = is_bslash ? esu_pkg::PH_ESC : esu_pkg::PH_TEXT;
        end
      end
      default: begin
        phase_mid = is_bslash ? esu_pkg::PH_ESC : esu_pkg::PH_TEXT;
      end
    endcase
    phase_next = stream_end ? esu_pkg::PH_TEXT : phase_mid;
  end

  always_comb begin
    entry             = '0;
    entry.a_val       = code_value;
    entry.b_val       = in_byte;
    digit_limit_next  = digit_limit;
    digits_taken_next = digits_taken;
    octal_radix_next  = octal_radix;
    code_value_next   = code_value;
    unique case (phase)
      esu_pkg::PH_ESC: begin
        if (simple_hit) begin
          entry.has_b = 1'b1;
          entry.b_val = simple_val;
        end else if (run_start) begin
          digit_limit_next  = run_lim;
          digits_taken_next = 4'd0;
          octal_radix_next  = 1'b0;
          code_value_next   = '0;
        end else if (is_oct) begin
          digit_limit_next  = esu_pkg::LIM_OCT;
          digits_taken_next = 4'd1;
          octal_radix_next  = 1'b1;
          code_value_next   = {29'd0, in_byte[2:0]};
        end else begin
          entry.has_b = 1'b1;
        end
      end
      esu_pkg::PH_DIGITS: begin
        if (take && !run_full) begin
          code_value_next   = shifted;
          digits_taken_next = taken_inc;
        end else begin
          entry.has_a       = 1'b1;
          entry.a_val       = take ? shifted : code_value;
          entry.has_b       = !take && !is_bslash;
          digit_limit_next  = 4'd0;
          digits_taken_next = 4'd0;
          octal_radix_next  = 1'b0;
          code_value_next   = '0;
        end
      end
      default: begin
        entry.has_b = !is_bslash;
      end
    endcase
    if (stream_end) begin
      if (phase_mid == esu_pkg::PH_ESC) begin
        entry.has_c = 1'b1;
      end else if (phase_mid == esu_pkg::PH_DIGITS) begin
        entry.has_a       = 1'b1;
        entry.a_val       = code_value_next;
        digit_limit_next  = 4'd0;
        digits_taken_next = 4'd0;
        octal_radix_next  = 1'b0;
        code_value_next   = '0;
      end
    end
  end

  assign q_valid = in_valid && (entry.has_a || entry.has_b || entry.has_c);
  assign q_data  = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= esu_pkg::PH_TEXT;
      digit_limit  <= '0;
      digits_taken <= '0;
      octal_radix  <= 1'b0;
      code_value   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      digit_limit  <= digit_limit_next;
      digits_taken <= digits_taken_next;
      octal_radix  <= octal_radix_next;
      code_value   <= code_value_next;
    end
  end

endmodule

// File: src/esu_back.sv
module esu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  esu_pkg::esu_entry_t q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                range_error
);

  esu_pkg::esu_entry_t cur;
  logic                cur_valid;
  logic [2:0]          k;

  logic                out_load;
  logic                emit;
  logic                done;
  logic                pop;
  logic                a_err;
  logic [2:0]          len_a;
  logic [2:0]          ncont;
  logic [1:0]          len_b;
  logic [3:0]          total;
  logic [3:0]          k4;
  logic [3:0]          kb;
  logic                in_a;
  logic                in_b;
  logic                is_last;
  logic [7:0]          lead_mark;
  logic [7:0]          a_byte;
  logic [7:0]          b_byte;
  logic [7:0]          byte_sel;

  function automatic logic [5:0] seg6(input logic [31:0] v, input logic [2:0] j);
    logic [35:0] w;
    w = {4'd0, v};
    case (j)
      3'd0:    seg6 = w[5:0];
      3'd1:    seg6 = w[11:6];
      3'd2:    seg6 = w[17:12];
      3'd3:    seg6 = w[23:18];
      3'd4:    seg6 = w[29:24];
      3'd5:    seg6 = w[35:30];
      default: seg6 = '0;
    endcase
  endfunction

  assign a_err = cur.a_val[31];

  always_comb begin
    if (!cur.has_a) begin
      len_a = 3'd0;
    end else if (a_err || cur.a_val < esu_pkg::UTF_LIM1) begin
      len_a = 3'd1;
    end else if (cur.a_val < esu_pkg::UTF_LIM2) begin
      len_a = 3'd2;
    end else if (cur.a_val < esu_pkg::UTF_LIM3) begin
      len_a = 3'd3;
    end else if (cur.a_val < esu_pkg::UTF_LIM4) begin
      len_a = 3'd4;
    end else if (cur.a_val < esu_pkg::UTF_LIM5) begin
      len_a = 3'd5;
    end else begin
      len_a = 3'd6;
    end
  end

  always_comb begin
    case (ncont)
      3'd1:    lead_mark = esu_pkg::UTF_LEAD2;
      3'd2:    lead_mark = esu_pkg::UTF_LEAD3;
      3'd3:    lead_mark = esu_pkg::UTF_LEAD4;
      3'd4:    lead_mark = esu_pkg::UTF_LEAD5;
      default: lead_mark = esu_pkg::UTF_LEAD6;
    endcase
  end

  assign ncont   = len_a - 3'd1;
  assign len_b   = cur.has_b ? (cur.b_val[7] ? 2'd2 : 2'd1) : 2'd0;
  assign total   = {1'b0, len_a} + {2'b0, len_b} + {3'b0, cur.has_c};
  assign k4      = {1'b0, k};
  assign kb      = k4 - {1'b0, len_a};
  assign in_a    = k4 < {1'b0, len_a};
  assign in_b    = kb < {2'b0, len_b};
  assign is_last = k4 == (total - 4'd1);

  always_comb begin
    if (a_err) begin
      a_byte = 8'h00;
    end else if (k == 3'd0) begin
      a_byte = (len_a == 3'd1) ? cur.a_val[7:0]
                               : lead_mark | {2'b00, seg6(cur.a_val, ncont)};
    end else begin
      a_byte = esu_pkg::UTF_CONT | {2'b00, seg6(cur.a_val, ncont - k)};
    end
  end

  always_comb begin
    if (!cur.b_val[7]) begin
      b_byte = cur.b_val;
    end else if (kb == 4'd0) begin
      b_byte = esu_pkg::UTF_LEAD2 | {6'd0, cur.b_val[7:6]};
    end else begin
      b_byte = esu_pkg::UTF_CONT | (cur.b_val & esu_pkg::UTF_MASK);
    end
  end

  assign byte_sel = in_a ? a_byte : (in_b ? b_byte : esu_pkg::CH_BSLASH);

  assign out_load = !out_valid || out_ready;
  assign emit     = cur_valid && out_load;
  assign done     = emit && is_last;
  assign q_ready  = !cur_valid || done;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (emit) begin
      out_byte    <= byte_sel;
      run_last    <= is_last;
      range_error <= in_a && a_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        k         <= '0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        k <= k + 3'd1;
      end
      if (out_load) begin
        out_valid <= cur_valid;
      end
    end
  end

endmodule

// File: src/escape_string_unescaper_utf8.sv
// An accepted item is registered in the queue, then in cur in the back end, then in out_byte.
// One input byte per cycle while in_ready is high; the back end sends one byte per cycle while
// out_ready allows; an item that decodes to n bytes holds it until all are sent (n up to 8).
// A 4-entry queue between front and back absorbs the expansion; in_ready drops when it fills.
// Reset (rst, synchronous, active high) returns to normal text and empties queue and output.
module escape_string_unescaper_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       range_error
);

  logic                wr_valid;
  logic                wr_ready;
  esu_pkg::esu_entry_t wr_data;
  logic                rd_valid;
  logic                rd_ready;
  esu_pkg::esu_entry_t rd_data;

  esu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .q_valid    (wr_valid),
    .q_ready    (wr_ready),
    .q_data     (wr_data)
  );

  esu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  esu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (rd_valid),
    .q_ready     (rd_ready),
    .q_data      (rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .range_error (range_error)
  );

endmodule

// File: src/esu_checker.sv
`include "escape_string_unescaper_utf8_defines.svh"

module esu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       range_error
);

  `ESU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ESU_ASSERT_NOW(a_reset_idle, $past(rst), !out_valid)
  `ESU_ASSERT_NOW(a_err_zero, out_valid && range_error, out_byte == 8'h00)
  `ESU_ASSERT_NOW(a_lead_not_last, out_valid && out_byte[7:6] == 2'b11, !run_last)

endmodule

bind escape_string_unescaper_utf8 esu_checker u_esu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .run_last    (run_last),
  .range_error (range_error)
);
